// ===== hw/rtl/sitar_pkg.sv =====
// shared types, constants and the digit-to-character mapping for the
// signed integer to ascii radix converter; no dependencies
package sitar_pkg;

   // default sizes
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int MAX_CHARS_DEF   = 32;

   // field widths fixed by the interface
   localparam int BASE_WIDTH    = 8;
   localparam int CHAR_WIDTH    = 8;
   localparam int DIVISOR_WIDTH = 6;
   localparam int DIGIT_WIDTH   = 5;

   // radix limits
   localparam logic [BASE_WIDTH-1:0] BASE_MIN     = 8'd2;
   localparam logic [BASE_WIDTH-1:0] BASE_MAX     = 8'd32;
   localparam logic [BASE_WIDTH-1:0] BASE_DECIMAL = 8'd10;

   // ascii codes
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_A     = 8'd65;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'd45;
   localparam logic [CHAR_WIDTH-1:0] ASCII_NUL   = 8'd0;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN  = 5'd10;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SIGN,
      ST_READ,
      ST_LOAD,
      ST_WAIT
   } sitar_state_type;

   // digit 0-9 to '0'-'9', 10-31 to 'A'-'V'
   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] dx;
      dx = {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, d};
      if (d >= DIGIT_TEN) begin
         return ASCII_A + dx - {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, DIGIT_TEN};
      end
      return ASCII_ZERO + dx;
   endfunction

endpackage

// ===== hw/rtl/sitar_divider.sv =====
// restoring divider, one quotient bit per cycle, small divisor (up to 32)
// depends on sitar_pkg
module sitar_divider #(
   parameter int WIDTH = sitar_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [WIDTH-1:0]                      dividend,
   input  logic [sitar_pkg::DIVISOR_WIDTH-1:0]   divisor,
   output logic                                  done,
   output logic [WIDTH-1:0]                      quotient,
   output logic [sitar_pkg::DIGIT_WIDTH-1:0]     remainder
);
   import sitar_pkg::*;

   localparam int CW = $clog2(WIDTH);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [WIDTH-1:0]        quo_ff, quo_in;
   logic [DIGIT_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0] shifted;
   logic [DIVISOR_WIDTH-1:0] diff;
   logic                    fits;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      fits    = (shifted >= divisor);
      diff    = shifted - divisor;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CW'(WIDTH - 1);
         quo_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[WIDTH-2:0], fits};
         rem_in   = fits ? diff[DIGIT_WIDTH-1:0] : shifted[DIGIT_WIDTH-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/signed_integer_to_ascii_radix.sv =====
// top level of the signed integer to ascii radix converter: sequencer,
// digit buffer and output register; depends on sitar_pkg and sitar_divider
//
// usage:
//  - req channel (req_valid/req_ready) takes one item: a signed value and
//    a base. req_ready is high only while the block is idle.
//  - rsp channel (rsp_valid/rsp_ready) returns the text one character per
//    item, most significant first, rsp_last on the final one. a leading
//    '-' appears for negative values in base 10 only. a base outside
//    2..32 gives a single item with rsp_invalid_base and rsp_last set.
//  - each digit is one pass through the shared divider (one quotient bit
//    per cycle); a sign check follows the last digit, then each character
//    passes through the digit buffer and the output register, waiting in
//    the output register until the receiver takes it.
//  - a stalled receiver holds the current character in the output
//    register; nothing else moves until it is taken.
//  - reset returns the sequencer to idle and drops rsp_valid.
module signed_integer_to_ascii_radix #(
   parameter int VALUE_WIDTH = sitar_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_CHARS   = sitar_pkg::MAX_CHARS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [VALUE_WIDTH-1:0]       req_value,
   input  logic [sitar_pkg::BASE_WIDTH-1:0]    req_base,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sitar_pkg::CHAR_WIDTH-1:0]    rsp_character,
   output logic                                rsp_last,
   output logic                                rsp_invalid_base
);
   import sitar_pkg::*;

   localparam int AW = $clog2(VALUE_WIDTH);
   localparam int LW = $clog2(VALUE_WIDTH + 1);
   localparam int CW = $clog2(MAX_CHARS);

   sitar_state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;
   logic [DIVISOR_WIDTH-1:0] base_ff, base_in;
   logic                     neg10_ff, neg10_in;
   logic [LW-1:0]            len_ff, len_in;
   logic [AW-1:0]            rd_idx_ff, rd_idx_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]    rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_inv_ff, rsp_inv_in;
   logic [CHAR_WIDTH-1:0]    rd_data_ff;

   logic [VALUE_WIDTH-1:0]   value_bits;
   logic                     value_neg;
   logic                     base_ok;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [CHAR_WIDTH-1:0]    wr_data;
   logic                     rd_en;
   logic                     div_start;
   logic                     div_done;
   logic [VALUE_WIDTH-1:0]   div_quotient;
   logic [DIGIT_WIDTH-1:0]   div_remainder;

   // digit buffer, least significant digit at address 0
   logic [CHAR_WIDTH-1:0] text_mem [VALUE_WIDTH];

   sitar_divider #(
      .WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_ff),
      .divisor   (base_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // sequencer next state and outputs
   always_comb begin
      value_bits = req_value;
      value_neg  = value_bits[VALUE_WIDTH-1];
      base_ok    = req_base inside {[BASE_MIN:BASE_MAX]};

      state_in     = state_ff;
      mag_in       = mag_ff;
      base_in      = base_ff;
      neg10_in     = neg10_ff;
      len_in       = len_ff;
      rd_idx_in    = rd_idx_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_inv_in   = rsp_inv_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = len_ff[AW-1:0];
      wr_data      = digit_char(div_remainder);
      rd_en        = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mag_in   = value_neg ? (~value_bits + VALUE_WIDTH'(1)) : value_bits;
               base_in  = req_base[DIVISOR_WIDTH-1:0];
               neg10_in = value_neg && (req_base == BASE_DECIMAL);
               len_in   = '0;
               cnt_in   = '0;
               if (base_ok) begin
                  state_in = ST_DIV_START;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = ASCII_NUL;
                  rsp_last_in  = 1'b1;
                  rsp_inv_in   = 1'b1;
                  state_in     = ST_WAIT;
               end
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               wr_en  = 1'b1;
               len_in = len_ff + 1'b1;
               mag_in = div_quotient;
               state_in = (div_quotient == '0) ? ST_SIGN : ST_DIV_START;
            end
         end
         ST_SIGN: begin
            wr_data = ASCII_MINUS;
            if (neg10_ff) begin
               wr_en     = 1'b1;
               len_in    = len_ff + 1'b1;
               rd_idx_in = len_ff[AW-1:0];
            end else begin
               rd_idx_in = AW'(len_ff - 1'b1);
            end
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = rd_data_ff;
            rsp_last_in  = (rd_idx_ff == '0) || (cnt_ff == CW'(MAX_CHARS - 1));
            rsp_inv_in   = 1'b0;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff - 1'b1;
                  cnt_in    = cnt_ff + 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      base_ff     <= base_in;
      neg10_ff    <= neg10_in;
      len_ff      <= len_in;
      rd_idx_ff   <= rd_idx_in;
      cnt_ff      <= cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_inv_ff  <= rsp_inv_in;
   end

   // digit buffer write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         text_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= text_mem[rd_idx_ff];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_character    = rsp_char_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_invalid_base = rsp_inv_ff;

`ifndef ASSERT_OFF
   // no new item taken while a character is pending
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("req_ready high while a result is pending");

   // an invalid base result is always the final item
   a_invalid_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid_base) |-> rsp_last)
      else $error("invalid base result without last");

   // divider completes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider done outside the wait state");

   // an accepted item closes the input side for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready stayed high after accepting an item");
`endif

endmodule

// ===== dv/signed_integer_to_ascii_radix_tb.sv =====
// testbench for signed_integer_to_ascii_radix: directed table then random items,
// every character checked against the typed row text or an in-bench text predictor
// depends on sitar_pkg and the signed_integer_to_ascii_radix rtl
`timescale 1ns / 100ps

module signed_integer_to_ascii_radix_tb;
   import sitar_pkg::*;

   localparam int VW           = VALUE_WIDTH_DEF;
   localparam int RANDOM_ITEMS = 187;
   localparam int HOLD_AT      = 150;   // character count at which the long stall starts
   localparam int HOLD_CYCLES  = 600;

   // one character of text as the block returns it
   typedef struct {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
      logic                  invalid_base;
   } char_item_type;

   // directed row; typed rows carry their text, or rejected for a bad base
   typedef struct {
      logic signed [VW-1:0]   value;
      logic [BASE_WIDTH-1:0]  base;
      bit                     typed;
      bit                     rejected;
      string                  text;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic signed [VW-1:0]   req_value = '0;
   logic [BASE_WIDTH-1:0]  req_base = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CHAR_WIDTH-1:0]  rsp_character;
   logic                   rsp_last;
   logic                   rsp_invalid_base;

   char_item_type  expected_chars[$];
   stim_row_type   stim_table[$];
   int             error_count = 0;
   bit             sender_burst = 1'b0;

   signed_integer_to_ascii_radix dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_base         (req_base),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .rsp_invalid_base (rsp_invalid_base)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // expected text of one number, most significant character first
   function automatic void predict_text(input logic [VW-1:0] value,
                                        input logic [BASE_WIDTH-1:0] base);
      logic [VW-1:0]          magnitude;
      logic [VW-1:0]          digit;
      logic [CHAR_WIDTH-1:0]  digits[$];
      int                     count;
      if (base < BASE_MIN || base > BASE_MAX) begin
         expected_chars.push_back('{ASCII_NUL, 1'b1, 1'b1});
         return;
      end
      // most negative value wraps to 2^(VW-1), which fits unsigned
      magnitude = value[VW-1] ? (~value + 1'b1) : value;
      while (magnitude != 0) begin
         digit = magnitude % base;
         if (digit >= 10)
            digits.push_back(ASCII_A + CHAR_WIDTH'(digit - 10));
         else
            digits.push_back(ASCII_ZERO + CHAR_WIDTH'(digit));
         magnitude = magnitude / base;
      end
      if (digits.size() == 0) digits.push_back(ASCII_ZERO);
      if (value[VW-1] && base == BASE_DECIMAL) digits.push_back(ASCII_MINUS);
      count = (digits.size() > MAX_CHARS_DEF) ? MAX_CHARS_DEF : digits.size();
      for (int k = 0; k < count; k++) begin
         expected_chars.push_back('{digits[digits.size() - 1 - k], k == count - 1, 1'b0});
      end
   endfunction

   function automatic void add_row(input logic signed [VW-1:0] value,
                                   input logic [BASE_WIDTH-1:0] base,
                                   input bit typed, input bit rejected, input string text);
      stim_row_type row;
      row.value    = value;
      row.base     = base;
      row.typed    = typed;
      row.rejected = rejected;
      row.text     = text;
      stim_table.push_back(row);
   endfunction

   // offer one item after a random gap (none in burst mode), return at the edge that takes it
   task automatic send_item(input logic signed [VW-1:0] value,
                            input logic [BASE_WIDTH-1:0] base);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_base  <= base;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // stimulus and end of run
   initial begin
      logic signed [VW-1:0]   value;
      logic [BASE_WIDTH-1:0]  base;
      stim_row_type           row;

      // extremes, sign handling, zero, bad bases
      add_row(32'sd0,          8'd10,  1, 0, "0");
      add_row(32'sd0,          8'd2,   1, 0, "0");
      add_row(-32'sd2147483648, 8'd10, 1, 0, "-2147483648");
      add_row(32'sd2147483647, 8'd10,  1, 0, "2147483647");
      add_row(-32'sd1,         8'd10,  1, 0, "-1");
      add_row(-32'sd1,         8'd16,  1, 0, "1");
      add_row(32'sd255,        8'd16,  1, 0, "FF");
      add_row(-32'sd255,       8'd16,  1, 0, "FF");
      add_row(32'sd31,         8'd32,  1, 0, "V");
      add_row(32'sd10,         8'd11,  1, 0, "A");
      add_row(32'sd10,         8'd10,  1, 0, "10");
      add_row(32'sd123,        8'd0,   1, 1, "");
      add_row(-32'sd1,         8'd1,   1, 1, "");
      add_row(32'sd7,          8'd33,  1, 1, "");
      add_row(-32'sd2147483648, 8'd255, 1, 1, "");
      add_row(-32'sd2147483648, 8'd2,  0, 0, "");
      add_row(32'sd2147483647, 8'd2,   0, 0, "");
      add_row(32'sd2147483647, 8'd32,  0, 0, "");
      add_row(-32'sd2147483648, 8'd32, 0, 0, "");
      add_row(-32'sd2147483648, 8'd16, 0, 0, "");
      add_row(32'sd12345,      8'd7,   0, 0, "");
      add_row(-32'sd98765,     8'd3,   0, 0, "");
      add_row(32'sd1,          8'd2,   0, 0, "");

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (stim_table[i]) begin
         row = stim_table[i];
         send_item(row.value, row.base);
         if (!row.typed) begin
            predict_text(row.value, row.base);
         end else if (row.rejected) begin
            expected_chars.push_back('{ASCII_NUL, 1'b1, 1'b1});
         end else begin
            for (int k = 0; k < row.text.len(); k++) begin
               expected_chars.push_back('{row.text[k], k == row.text.len() - 1, 1'b0});
            end
         end
      end

      // random items, mostly valid bases; base 2 kept rare since it is slowest
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sender_burst = (n >= 60 && n < 100);
         case ($urandom_range(0, 7))
            0: begin
               value = $urandom_range(0, 40);
               if ($urandom_range(0, 1)) value = -value;
            end
            1: begin
               case ($urandom_range(0, 4))
                  0: value = {1'b1, {(VW-1){1'b0}}};
                  1: value = {1'b0, {(VW-1){1'b1}}};
                  2: value = '1;
                  3: value = '0;
                  default: value = 1;
               endcase
            end
            default: value = $urandom;
         endcase
         case ($urandom_range(0, 15))
            0: base = BASE_WIDTH'($urandom_range(0, 1));
            1: base = BASE_WIDTH'($urandom_range(33, 255));
            2: base = BASE_MIN;
            3, 4, 5, 6: base = BASE_DECIMAL;
            7: base = 8'd16;
            8: base = BASE_MAX;
            default: base = BASE_WIDTH'($urandom_range(3, 32));
         endcase
         send_item(value, base);
         predict_text(value, base);
      end
      req_valid <= 1'b0;

      // drain, then watch for stray characters
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("signed_integer_to_ascii_radix verification clean");
      end else begin
         $display("signed_integer_to_ascii_radix verification failed");
      end
      $finish;
   end

   // receiver: random stall per character, one long hold, a stretch with none
   initial begin
      int stall;
      int rx_count;
      bit held;
      rx_count = 0;
      held     = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rx_count >= 400 && rx_count < 700) stall = 0;
         else stall = $urandom_range(0, 15);
         if (rx_count == HOLD_AT && !held) begin
            stall = HOLD_CYCLES;
            held  = 1'b1;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         rx_count++;
      end
   end

   // compare each accepted character with the oldest expectation
   always @(posedge clock) begin : rsp_check
      char_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            error_count++;
            $error("unexpected character item %0h", rsp_character);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_character !== want.character) begin
               error_count++;
               $error("character expected %0h actual %0h", want.character, rsp_character);
            end
            if (rsp_last !== want.last) begin
               error_count++;
               $error("last expected %0b actual %0b", want.last, rsp_last);
            end
            if (rsp_invalid_base !== want.invalid_base) begin
               error_count++;
               $error("invalid_base expected %0b actual %0b",
                      want.invalid_base, rsp_invalid_base);
            end
         end
      end
   end

   // run limit, well above the slowest legal run
   initial begin
      #20_000_000;
      $display("signed_integer_to_ascii_radix verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/sitar_pkg.sv
hw/rtl/sitar_divider.sv
hw/rtl/signed_integer_to_ascii_radix.sv
dv/signed_integer_to_ascii_radix_tb.sv
